>>> rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the ARP cache responder: command and result
// payloads, status bundle, register map and protocol field values.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

    // item kinds
    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // protocol checks
    localparam logic [10:0] MIN_PAYLOAD = 11'd28;
    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [15:0] OP_REQUEST  = 16'h0001;

    // register map, selected by paddr[3]
    localparam logic REG_OWN_IP  = 1'b0;
    localparam logic REG_OWN_MAC = 1'b1;

    localparam logic [31:0] OWN_IP_RESET  = 32'h0A00_020F;
    localparam logic [47:0] OWN_MAC_RESET = 48'h0;

    typedef struct packed {
        logic        kind;
        logic [10:0] payload_len;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [15:0] operation;
        logic [47:0] sender_mac;
        logic [31:0] src_ip;
        logic [31:0] tgt_ip;
        logic [31:0] query_ip;
    } cmd_t;

    typedef struct packed {
        logic        accepted;
        logic        send_reply;
        logic [47:0] reply_dest_mac;
        logic [31:0] reply_target_ip;
        logic        lookup_hit;
        logic [47:0] lookup_mac;
    } result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } status_t;

endpackage : arpc_pkg

`default_nettype wire

>>> rtl/arpc_ram.sv
// ----------------------------------------------------------------------------
// arpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule : arpc_ram

`default_nettype wire

>>> rtl/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer of the ARP cache: sweeps the table one slot per cycle through a
// single compare unit, then learns the sender or reports the lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_ctrl
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire cmd_t    cmd,
    input  wire logic [31:0] own_ip,
    output      status_t status,
    output      result_t result
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    cmd_t    item_reg, item_next;
    result_t result_reg, result_next;
    logic    done_reg, done_next;

    logic [CW-1:0] issue_cnt_reg, issue_cnt_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0] cmp_idx_reg, cmp_idx_next;

    logic          found_reg, found_next;
    logic [IW-1:0] found_idx_reg, found_idx_next;
    logic [47:0]   found_mac_reg, found_mac_next;
    logic          free_reg, free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;

    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    // table storage: {ip, mac}
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [79:0]   ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [79:0]   ram_rdata;

    logic [31:0] key_ip;
    logic        slot_hit;
    logic        pkt_pass;
    logic        is_reply;
    logic [IW-1:0] learn_idx;

    arpc_ram #(
        .WIDTH (80),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared compare unit
    assign key_ip   = (item_reg.kind == KIND_LOOKUP) ? item_reg.query_ip : item_reg.src_ip;
    assign slot_hit = valid_reg[cmp_idx_reg] && (ram_rdata[79:48] == key_ip);

    // packet checks
    assign pkt_pass = (item_reg.kind == KIND_PACKET)
                   && (item_reg.payload_len >= MIN_PAYLOAD)
                   && (item_reg.hw_type == HW_ETHERNET)
                   && (item_reg.proto_type == PROTO_IPV4);
    assign is_reply = (item_reg.operation == OP_REQUEST) && (item_reg.tgt_ip == own_ip);

    // slot to learn into: match, else lowest free, else slot 0
    assign learn_idx = found_reg ? found_idx_reg : (free_reg ? free_idx_reg : '0);

    assign ram_raddr = issue_cnt_reg[IW-1:0];
    assign ram_waddr = learn_idx;
    assign ram_wdata = {item_reg.src_ip, item_reg.sender_mac};
    assign ram_we    = (state_reg == ST_FINISH) && pkt_pass;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        result_next    = result_reg;
        done_next      = 1'b0;
        issue_cnt_next = issue_cnt_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        found_mac_next = found_mac_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        valid_next     = valid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next      = cmd;
                    issue_cnt_next = '0;
                    found_next     = 1'b0;
                    free_next      = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // issue one table read per cycle
                if (issue_cnt_reg < LAST_CNT)
                begin
                    cmp_vld_next   = 1'b1;
                    cmp_idx_next   = issue_cnt_reg[IW-1:0];
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                else if (!cmp_vld_reg)
                begin
                    state_next = ST_FINISH;
                end
                // compare the slot read last cycle
                if (cmp_vld_reg)
                begin
                    if (slot_hit && !found_reg)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = cmp_idx_reg;
                        found_mac_next = ram_rdata[47:0];
                    end
                    if (!valid_reg[cmp_idx_reg] && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                end
            end
            ST_FINISH:
            begin
                result_next = '0;
                if (item_reg.kind == KIND_LOOKUP)
                begin
                    result_next.lookup_hit = found_reg;
                    result_next.lookup_mac = found_reg ? found_mac_reg : 48'h0;
                end
                else if (pkt_pass)
                begin
                    valid_next[learn_idx] = 1'b1;
                    result_next.accepted  = 1'b1;
                    if (is_reply)
                    begin
                        result_next.send_reply      = 1'b1;
                        result_next.reply_dest_mac  = item_reg.sender_mac;
                        result_next.reply_target_ip = item_reg.src_ip;
                    end
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            valid_reg     <= '0;
            issue_cnt_reg <= '0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            cmp_vld_reg   <= cmp_vld_next;
            valid_reg     <= valid_next;
            issue_cnt_reg <= issue_cnt_next;
            found_reg     <= found_next;
            free_reg      <= free_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        result_reg    <= result_next;
        cmp_idx_reg   <= cmp_idx_next;
        found_idx_reg <= found_idx_next;
        found_mac_reg <= found_mac_next;
        free_idx_reg  <= free_idx_next;
    end

    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = done_reg;
    assign result      = result_reg;

endmodule : arpc_ctrl

`default_nettype wire

>>> rtl/arp_cache_responder_top.sv
// ----------------------------------------------------------------------------
// arp_cache_responder_top
// ARP cache with request responder: learns sender bindings from received
// ARP packets, flags replies to requests for our address, answers lookups.
//
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+-------------------
// command  | in        | start & !busy              | cmd (cmd_t)
// result   | out       | done, one cycle            | result (result_t)
// config   | in        | psel & penable & pwrite    | paddr, pwdata
//
// each item sweeps the table one slot per cycle through one compare unit;
// the next item may start in the done cycle.
// reset clears the valid bits at once; slot contents need no clearing.
// the receiver cannot stall: done is high for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_responder_top
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command
    input  wire logic        start,
    output      logic        busy,
    input  wire cmd_t        cmd,
    // result
    output      logic        done,
    output      result_t     result,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output      logic [63:0] prdata,
    output      logic        pready
);

    logic [31:0] own_ip_reg, own_ip_next;
    logic [47:0] own_mac_reg, own_mac_next;
    logic        cfg_wr;
    logic        reg_sel;
    status_t     status;

    // register file write
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3];

    always_comb
    begin
        own_ip_next  = own_ip_reg;
        own_mac_next = own_mac_reg;
        if (cfg_wr)
        begin
            case (reg_sel)
                REG_OWN_IP:  own_ip_next  = pwdata[31:0];
                REG_OWN_MAC: own_mac_next = pwdata[47:0];
                default:     own_ip_next  = own_ip_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= OWN_IP_RESET;
            own_mac_reg <= OWN_MAC_RESET;
        end
        else
        begin
            own_ip_reg  <= own_ip_next;
            own_mac_reg <= own_mac_next;
        end
    end

    // register read back
    always_comb
    begin
        case (reg_sel)
            REG_OWN_IP:  prdata = {32'h0, own_ip_reg};
            REG_OWN_MAC: prdata = {16'h0, own_mac_reg};
            default:     prdata = 64'h0;
        endcase
    end

    // table sequencer
    arpc_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .own_ip (own_ip_reg),
        .status (status),
        .result (result)
    );

    assign busy = status.busy;
    assign done = status.done;

    // checks
    a_done_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a sweep is running");

    a_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not start a sweep");

    a_kind_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.accepted && result.lookup_hit))
        else $error("result marks both a learned packet and a lookup hit");

    a_reply_learned : assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.send_reply) |-> result.accepted)
        else $error("reply requested for a packet that was not learned");

    a_no_back_to_back : assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two result strobes in a row");

endmodule : arp_cache_responder_top

`default_nettype wire
